### src/btd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btd_pkg
// Types and constants shared by the battery telemetry decoder modules.
// ----------------------------------------------------------------------------
package btd_pkg;

    // Field widths
    localparam int VBAT_W      = 13;
    localparam int TEMP_W      = 14;
    localparam int IBAT_W      = 12;
    localparam int SOC_W       = 7;
    localparam int CSTATE_W    = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int CUR_CFG_W   = 10;
    localparam int TERM_W      = 13;
    localparam int SOC_NUM_W   = 18;
    localparam int DIV_STAGES  = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_CURRENT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCHARGE_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TERM_VOLTAGE    = 2'd2;

    // Configuration reset values
    localparam logic [CUR_CFG_W-1:0] CHARGE_CURRENT_RST  = 10'd400;
    localparam logic [CUR_CFG_W-1:0] DISCHARGE_LIMIT_RST = 10'd1000;
    localparam logic [TERM_W-1:0]    TERM_VOLTAGE_RST    = 13'd4100;

    // Current status nibble codes
    localparam logic [3:0] NIB_CHG_C = 4'hC;
    localparam logic [3:0] NIB_CHG_D = 4'hD;
    localparam logic [3:0] NIB_CHG_F = 4'hF;
    localparam logic [3:0] NIB_DIS   = 4'h4;

    // Charger status bit positions
    localparam int CHG_BIT_DETECT   = 0;
    localparam int CHG_BIT_CHARGED  = 1;
    localparam int CHG_BIT_TRICKLE  = 2;
    localparam int CHG_BIT_CC       = 3;
    localparam int CHG_BIT_CV       = 4;
    localparam int CHG_BIT_RECHARGE = 5;
    localparam int CHG_BIT_HOT      = 6;
    localparam int CHG_BIT_SUPPL    = 7;

    // Arithmetic constants; reciprocals are ceil(2^k / d), exact over the operand range
    localparam logic [12:0]        VREF_MV          = 13'd5000;
    localparam logic [12:0]        TEMP_SLOPE_X10   = 13'd7926;
    localparam logic signed [20:0] TEMP_OFFSET_MDEG = 21'sd394670;
    localparam logic [22:0]        RECIP_DIV10      = 23'd6710887;   // k = 26
    localparam logic [19:0]        RECIP_DIV100     = 20'd671089;    // k = 26
    localparam logic [14:0]        DIS_FS_MUL       = 15'd28;        // 112/100 = 28/25
    localparam logic [15:0]        RECIP_DIV25      = 16'd41944;     // k = 20
    localparam logic [22:0]        RECIP_DIV1023    = 23'd4198405;   // k = 32
    localparam logic [14:0]        IR_RECIP         = 15'd20972;     // 160/1000 = 4/25, k = 17
    localparam logic [13:0]        SOC_FLOOR_MV     = 14'd3500;
    localparam logic [TERM_W-1:0]  SOC_SPAN_DEFAULT = 13'd700;
    localparam logic [SOC_W-1:0]   SOC_FULL         = 7'd100;

    typedef enum logic [1:0] {
        IDIR_NONE,
        IDIR_CHG,
        IDIR_DIS
    } idir_t;

    typedef enum logic [CSTATE_W-1:0] {
        CS_NO_BATTERY = 4'd0,
        CS_HOT_PAUSE  = 4'd1,
        CS_CHARGED    = 4'd2,
        CS_TRICKLE    = 4'd3,
        CS_CC         = 4'd4,
        CS_CV         = 4'd5,
        CS_RECHARGE   = 4'd6,
        CS_ASSIST     = 4'd7,
        CS_IDLE       = 4'd8
    } cstate_t;

    typedef struct packed {
        logic       read_ok;
        logic [7:0] vbat_high_byte;
        logic [7:0] temp_high_byte;
        logic [7:0] low_bits_a;
        logic [7:0] current_status;
        logic [7:0] current_high_byte;
        logic [7:0] low_bits_b;
        logic [7:0] charger_status;
        logic [7:0] vbus_status;
    } btd_raw_t;

    typedef struct packed {
        logic                     ok;
        logic [VBAT_W-1:0]        vbat;
        logic signed [TEMP_W-1:0] temp;
        logic signed [IBAT_W-1:0] ibat;
        cstate_t                  cstate;
        logic                     supply;
    } btd_fields_t;

endpackage

### src/battery_telemetry_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_telemetry_decoder
// Decodes one set of raw charger telemetry bytes per transaction into
// voltage, temperature, current, state of charge and charge state.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one raw register set per transaction (valid/ready).
//   m_* returns one decoded result per input transaction, in order.
//   cfg_* writes charge setpoint (index 0), discharge limit (1) and
//   termination voltage (2); cfg_ready is always high. Write only while
//   no transaction is in flight.
//   The pipeline has five scaling stages, then eight stages of the
//   state-of-charge divider, one quotient bit each. A new transaction is
//   taken every cycle unless a waiting result with m_ready low holds it.
//   The last divider stage is the output register. When m_ready is low
//   with a result waiting, the whole pipeline holds and s_ready drops;
//   nothing is lost or repeated.
//   A transaction with read_ok low returns valid_res 0 and all-zero fields.
//   Reset (aresetn, synchronous) empties the pipeline and restores the
//   configuration defaults 400 mA, 1000 mA and 4100 mV.
// ----------------------------------------------------------------------------
module battery_telemetry_decoder (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_read_ok,
    input  logic [7:0]                        s_vbat_high_byte,
    input  logic [7:0]                        s_temp_high_byte,
    input  logic [7:0]                        s_low_bits_a,
    input  logic [7:0]                        s_current_status,
    input  logic [7:0]                        s_current_high_byte,
    input  logic [7:0]                        s_low_bits_b,
    input  logic [7:0]                        s_charger_status,
    input  logic [7:0]                        s_vbus_status,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_valid_res,
    output logic [btd_pkg::VBAT_W-1:0]        m_vbat_mv,
    output logic signed [btd_pkg::TEMP_W-1:0] m_die_temp_tenths,
    output logic signed [btd_pkg::IBAT_W-1:0] m_ibat_ma,
    output logic [btd_pkg::SOC_W-1:0]         m_soc_percent,
    output logic [btd_pkg::CSTATE_W-1:0]      m_charge_state,
    output logic                              m_supply_present,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [btd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [btd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import btd_pkg::*;

    logic [CUR_CFG_W-1:0] charge_current_reg;
    logic [CUR_CFG_W-1:0] discharge_limit_reg;
    logic [TERM_W-1:0]    term_voltage_reg;
    logic [TERM_W-1:0]    span;

    logic                 en;
    btd_raw_t             raw;
    logic                 sc_valid;
    btd_fields_t          sc_fields;
    logic [SOC_NUM_W-1:0] sc_num;
    logic                 sc_zero;
    btd_fields_t          out_fields;
    logic [SOC_W-1:0]     out_soc;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            charge_current_reg  <= CHARGE_CURRENT_RST;
            discharge_limit_reg <= DISCHARGE_LIMIT_RST;
            term_voltage_reg    <= TERM_VOLTAGE_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_CHARGE_CURRENT:  charge_current_reg  <= cfg_data[CUR_CFG_W-1:0];
                CFG_DISCHARGE_LIMIT: discharge_limit_reg <= cfg_data[CUR_CFG_W-1:0];
                CFG_TERM_VOLTAGE:    term_voltage_reg    <= cfg_data[TERM_W-1:0];
                default: ;
            endcase
        end
    end

    // span falls back to the default when termination is at or below the floor
    assign span = (term_voltage_reg > TERM_W'(SOC_FLOOR_MV))
                ? term_voltage_reg - TERM_W'(SOC_FLOOR_MV)
                : SOC_SPAN_DEFAULT;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    always_comb begin
        raw.read_ok           = s_read_ok;
        raw.vbat_high_byte    = s_vbat_high_byte;
        raw.temp_high_byte    = s_temp_high_byte;
        raw.low_bits_a        = s_low_bits_a;
        raw.current_status    = s_current_status;
        raw.current_high_byte = s_current_high_byte;
        raw.low_bits_b        = s_low_bits_b;
        raw.charger_status    = s_charger_status;
        raw.vbus_status       = s_vbus_status;
    end

    btd_scale u_scale (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .en                 (en),
        .in_valid           (s_valid),
        .raw                (raw),
        .charge_current_ma  (charge_current_reg),
        .discharge_limit_ma (discharge_limit_reg),
        .out_valid          (sc_valid),
        .out_fields         (sc_fields),
        .soc_num            (sc_num),
        .soc_zero           (sc_zero)
    );

    btd_soc_div u_soc_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (sc_valid),
        .in_fields   (sc_fields),
        .soc_num     (sc_num),
        .soc_zero    (sc_zero),
        .span        (span),
        .out_valid   (m_valid),
        .out_fields  (out_fields),
        .soc_percent (out_soc)
    );

    // failed reads come out as all zeros
    always_comb begin
        m_valid_res       = out_fields.ok;
        m_vbat_mv         = out_fields.ok ? out_fields.vbat : '0;
        m_die_temp_tenths = out_fields.ok ? out_fields.temp : '0;
        m_ibat_ma         = out_fields.ok ? out_fields.ibat : '0;
        m_soc_percent     = out_fields.ok ? out_soc : '0;
        m_charge_state    = out_fields.ok ? CSTATE_W'(out_fields.cstate) : '0;
        m_supply_present  = out_fields.ok && out_fields.supply;
    end

endmodule

### src/btd_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btd_scale
// Five-stage scaling pipeline: code assembly, voltage, temperature and
// current scaling, IR drop and the state-of-charge numerator.
// ----------------------------------------------------------------------------
module btd_scale (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  btd_pkg::btd_raw_t                 raw,
    input  logic [btd_pkg::CUR_CFG_W-1:0]     charge_current_ma,
    input  logic [btd_pkg::CUR_CFG_W-1:0]     discharge_limit_ma,
    output logic                              out_valid,
    output btd_pkg::btd_fields_t              out_fields,
    output logic [btd_pkg::SOC_NUM_W-1:0]     soc_num,
    output logic                              soc_zero
);
    import btd_pkg::*;

    // ---------------- stage 1 ----------------
    logic [9:0]  vcode, tcode, icode;
    logic [22:0] vprod_next, tprod_next;
    logic [10:0] fs_chg, fs_next;
    logic [14:0] dis28;
    logic [30:0] fs_dis_prod;
    idir_t       dir_next;
    cstate_t     cstate_next;

    logic        s1_valid_reg, s1_ok_reg, s1_supply_reg;
    logic [22:0] s1_vprod_reg, s1_tprod_reg;
    logic [9:0]  s1_icode_reg;
    logic [10:0] s1_fs_reg;
    idir_t       s1_dir_reg;
    cstate_t     s1_cstate_reg;

    always_comb begin
        vcode = {raw.vbat_high_byte, raw.low_bits_a[1:0]};
        tcode = {raw.temp_high_byte, raw.low_bits_a[5:4]};
        icode = {raw.current_high_byte, raw.low_bits_b[5:4]};

        vprod_next = 23'(vcode) * 23'(VREF_MV);
        tprod_next = 23'(tcode) * 23'(TEMP_SLOPE_X10);

        // full scale: setpoint*5/4 when charging, limit*28/25 when discharging
        fs_chg      = 11'(charge_current_ma) + 11'(charge_current_ma >> 2);
        dis28       = 15'(discharge_limit_ma) * DIS_FS_MUL;
        fs_dis_prod = 31'(dis28) * 31'(RECIP_DIV25);

        unique case (raw.current_status[3:0]) inside
            NIB_CHG_C, NIB_CHG_D, NIB_CHG_F: dir_next = IDIR_CHG;
            NIB_DIS:                         dir_next = IDIR_DIS;
            default:                         dir_next = IDIR_NONE;
        endcase
        fs_next = (dir_next == IDIR_CHG) ? fs_chg : fs_dis_prod[30:20];

        // first matching flag wins
        if (!raw.charger_status[CHG_BIT_DETECT])
            cstate_next = CS_NO_BATTERY;
        else if (raw.charger_status[CHG_BIT_HOT])
            cstate_next = CS_HOT_PAUSE;
        else if (raw.charger_status[CHG_BIT_CHARGED])
            cstate_next = CS_CHARGED;
        else if (raw.charger_status[CHG_BIT_TRICKLE])
            cstate_next = CS_TRICKLE;
        else if (raw.charger_status[CHG_BIT_CC])
            cstate_next = CS_CC;
        else if (raw.charger_status[CHG_BIT_CV])
            cstate_next = CS_CV;
        else if (raw.charger_status[CHG_BIT_RECHARGE])
            cstate_next = CS_RECHARGE;
        else if (raw.charger_status[CHG_BIT_SUPPL])
            cstate_next = CS_ASSIST;
        else
            cstate_next = CS_IDLE;
    end

    // ---------------- stage 2 ----------------
    logic [45:0] tq_prod;
    logic [12:0] vbat2_next;
    logic [19:0] tq_next;
    logic [20:0] iprod_next;

    logic        s2_valid_reg, s2_ok_reg, s2_supply_reg;
    logic [12:0] s2_vbat_reg;
    logic [19:0] s2_tq_reg;
    logic [20:0] s2_iprod_reg;
    idir_t       s2_dir_reg;
    cstate_t     s2_cstate_reg;

    always_comb begin
        vbat2_next = s1_vprod_reg[22:10];
        tq_prod    = 46'(s1_tprod_reg) * 46'(RECIP_DIV10);
        tq_next    = tq_prod[45:26];
        iprod_next = 21'(s1_icode_reg) * 21'(s1_fs_reg);
    end

    // ---------------- stage 3 ----------------
    logic signed [20:0] tdiff;
    logic [20:0]        tdiff_abs;
    logic [43:0]        iq_prod;
    logic [10:0]        imag_next;

    logic        s3_valid_reg, s3_ok_reg, s3_supply_reg, s3_tneg_reg;
    logic [12:0] s3_vbat_reg;
    logic [18:0] s3_tabs_reg;
    logic [10:0] s3_imag_reg;
    idir_t       s3_dir_reg;
    cstate_t     s3_cstate_reg;

    always_comb begin
        tdiff     = TEMP_OFFSET_MDEG - signed'({1'b0, s2_tq_reg});
        tdiff_abs = tdiff[20] ? 21'(-tdiff) : 21'(tdiff);
        iq_prod   = 44'(s2_iprod_reg) * 44'(RECIP_DIV1023);
        imag_next = iq_prod[42:32];
    end

    // ---------------- stage 4 ----------------
    logic [38:0]              tm_prod;
    logic [25:0]              ir_prod;
    logic signed [IBAT_W-1:0] ibat_next;

    logic                     s4_valid_reg, s4_ok_reg, s4_supply_reg, s4_tneg_reg;
    logic [12:0]              s4_vbat_reg;
    logic [12:0]              s4_tmag_reg;
    logic signed [IBAT_W-1:0] s4_ibat_reg;
    logic [7:0]               s4_irmag_reg;
    idir_t                    s4_dir_reg;
    cstate_t                  s4_cstate_reg;

    always_comb begin
        tm_prod = 39'(s3_tabs_reg) * 39'(RECIP_DIV100);
        ir_prod = 26'(s3_imag_reg) * 26'(IR_RECIP);
        unique case (s3_dir_reg)
            IDIR_CHG: ibat_next = IBAT_W'(s3_imag_reg);
            IDIR_DIS: ibat_next = IBAT_W'(0) - IBAT_W'(s3_imag_reg);
            default:  ibat_next = '0;
        endcase
    end

    // ---------------- stage 5 ----------------
    logic signed [TEMP_W-1:0] temp_next;
    logic signed [13:0]       ir_adj, socx;
    logic [10:0]              socx_u;
    logic [SOC_NUM_W-1:0]     num_next;
    logic                     zero_next;

    logic                     s5_valid_reg, s5_zero_reg;
    logic [SOC_NUM_W-1:0]     s5_num_reg;
    btd_fields_t              s5_fields_reg;

    always_comb begin
        temp_next = s4_tneg_reg ? TEMP_W'(0) - TEMP_W'(s4_tmag_reg) : TEMP_W'(s4_tmag_reg);
        unique case (s4_dir_reg)
            IDIR_CHG: ir_adj = 14'(s4_irmag_reg);
            IDIR_DIS: ir_adj = 14'(0) - 14'(s4_irmag_reg);
            default:  ir_adj = '0;
        endcase
        // open-circuit estimate above the floor
        socx      = signed'(14'(s4_vbat_reg)) - signed'(SOC_FLOOR_MV) - ir_adj;
        zero_next = socx[13] || (socx == '0);
        socx_u    = socx[10:0];
        num_next  = (SOC_NUM_W'(socx_u) << 6) + (SOC_NUM_W'(socx_u) << 5)
                  + (SOC_NUM_W'(socx_u) << 2);
    end

    // ---------------- valid bits ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    // ---------------- payload ----------------
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_ok_reg     <= raw.read_ok;
            s1_supply_reg <= raw.vbus_status[0];
            s1_vprod_reg  <= vprod_next;
            s1_tprod_reg  <= tprod_next;
            s1_icode_reg  <= icode;
            s1_fs_reg     <= fs_next;
            s1_dir_reg    <= dir_next;
            s1_cstate_reg <= cstate_next;

            s2_ok_reg     <= s1_ok_reg;
            s2_supply_reg <= s1_supply_reg;
            s2_vbat_reg   <= vbat2_next;
            s2_tq_reg     <= tq_next;
            s2_iprod_reg  <= iprod_next;
            s2_dir_reg    <= s1_dir_reg;
            s2_cstate_reg <= s1_cstate_reg;

            s3_ok_reg     <= s2_ok_reg;
            s3_supply_reg <= s2_supply_reg;
            s3_vbat_reg   <= s2_vbat_reg;
            s3_tneg_reg   <= tdiff[20];
            s3_tabs_reg   <= tdiff_abs[18:0];
            s3_imag_reg   <= imag_next;
            s3_dir_reg    <= s2_dir_reg;
            s3_cstate_reg <= s2_cstate_reg;

            s4_ok_reg     <= s3_ok_reg;
            s4_supply_reg <= s3_supply_reg;
            s4_vbat_reg   <= s3_vbat_reg;
            s4_tneg_reg   <= s3_tneg_reg;
            s4_tmag_reg   <= tm_prod[38:26];
            s4_ibat_reg   <= ibat_next;
            s4_irmag_reg  <= ir_prod[24:17];
            s4_dir_reg    <= s3_dir_reg;
            s4_cstate_reg <= s3_cstate_reg;

            s5_fields_reg.ok     <= s4_ok_reg;
            s5_fields_reg.vbat   <= s4_vbat_reg;
            s5_fields_reg.temp   <= temp_next;
            s5_fields_reg.ibat   <= s4_ibat_reg;
            s5_fields_reg.cstate <= s4_cstate_reg;
            s5_fields_reg.supply <= s4_supply_reg;
            s5_num_reg           <= num_next;
            s5_zero_reg          <= zero_next;
        end
    end

    assign out_valid  = s5_valid_reg;
    assign out_fields = s5_fields_reg;
    assign soc_num    = s5_num_reg;
    assign soc_zero   = s5_zero_reg;

endmodule

### src/btd_soc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btd_soc_div
// Pipelined restoring divider for the state-of-charge percentage, one
// quotient bit per stage, with clamping to 0..100 at the end.
// ----------------------------------------------------------------------------
module btd_soc_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  btd_pkg::btd_fields_t          in_fields,
    input  logic [btd_pkg::SOC_NUM_W-1:0] soc_num,
    input  logic                          soc_zero,
    input  logic [btd_pkg::TERM_W-1:0]    span,
    output logic                          out_valid,
    output btd_pkg::btd_fields_t          out_fields,
    output logic [btd_pkg::SOC_W-1:0]     soc_percent
);
    import btd_pkg::*;

    localparam int SHIFT_W = TERM_W + DIV_STAGES - 1;

    logic [DIV_STAGES-1:0] valid_reg;
    logic [DIV_STAGES-1:0] zero_reg;
    logic [SOC_NUM_W-1:0]  rem_reg  [DIV_STAGES];
    logic [DIV_STAGES-1:0] quo_reg  [DIV_STAGES];
    btd_fields_t           fld_reg  [DIV_STAGES];

    logic [SOC_NUM_W-1:0]  rem_in   [DIV_STAGES];
    logic [DIV_STAGES-1:0] quo_in   [DIV_STAGES];
    logic [SOC_NUM_W-1:0]  rem_next [DIV_STAGES];
    logic [DIV_STAGES-1:0] quo_next [DIV_STAGES];
    logic [SHIFT_W-1:0]    divisor  [DIV_STAGES];
    logic [SHIFT_W:0]      diff     [DIV_STAGES];

    always_comb begin
        rem_in[0] = soc_num;
        quo_in[0] = '0;
        for (int k = 1; k < DIV_STAGES; k++) begin
            rem_in[k] = rem_reg[k-1];
            quo_in[k] = quo_reg[k-1];
        end
        // stage k tries quotient bit DIV_STAGES-1-k; top bit set means saturate
        for (int k = 0; k < DIV_STAGES; k++) begin
            divisor[k]  = SHIFT_W'(span) << (DIV_STAGES - 1 - k);
            diff[k]     = {1'b0, SHIFT_W'(rem_in[k])} - {1'b0, divisor[k]};
            rem_next[k] = diff[k][SHIFT_W] ? rem_in[k] : diff[k][SOC_NUM_W-1:0];
            quo_next[k] = {quo_in[k][DIV_STAGES-2:0], ~diff[k][SHIFT_W]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[DIV_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg <= {zero_reg[DIV_STAGES-2:0], soc_zero};
            fld_reg[0] <= in_fields;
            for (int k = 1; k < DIV_STAGES; k++) begin
                fld_reg[k] <= fld_reg[k-1];
            end
            for (int k = 0; k < DIV_STAGES; k++) begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
            end
        end
    end

    logic [DIV_STAGES-1:0] quo_last;

    always_comb begin
        quo_last = quo_reg[DIV_STAGES-1];
        if (zero_reg[DIV_STAGES-1])
            soc_percent = '0;
        else if (quo_last[DIV_STAGES-1] || (quo_last[SOC_W-1:0] > SOC_FULL))
            soc_percent = SOC_FULL;
        else
            soc_percent = quo_last[SOC_W-1:0];
    end

    assign out_valid  = valid_reg[DIV_STAGES-1];
    assign out_fields = fld_reg[DIV_STAGES-1];

endmodule
